FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the request queue checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define SWRQ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define SWRQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/swrq_pkg.sv
// ----------------------------------------------------------------------------
// swrq_pkg
// Types, codes and defaults shared by the stop-and-wait request queue.
// ----------------------------------------------------------------------------
`default_nettype none

package swrq_pkg;

  // Default sizing of the pending request store.
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TAG_BITS_DEF    = 8;

  // Fixed field widths of the transactions.
  localparam int CMD_W    = 3;
  localparam int TAG_W    = 8;
  localparam int SEQ_W    = 16;
  localparam int ACTION_W = 8;
  localparam int EVT_W    = 3;
  localparam int AGE_W    = 16;
  localparam int RETRY_W  = 4;

  // Configuration port.
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_RETRIES = 1'b1;
  localparam logic [AGE_W-1:0]      TIMEOUT_RST = 16'd1000;
  localparam logic [RETRY_W-1:0]    RETRIES_RST = 4'd3;

  // Saturation limits of the head counters.
  localparam logic [AGE_W-1:0]   AGE_MAX   = '1;
  localparam logic [RETRY_W-1:0] RETRY_MAX = '1;

  // Received action byte that resets the link.
  localparam logic [ACTION_W-1:0] ACTION_RESET = 8'h07;

  // Input commands.
  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ENQ     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RX      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CONNECT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DISC    = 3'd4;

  // Result events.
  localparam logic [EVT_W-1:0] EVT_NONE    = 3'd0;
  localparam logic [EVT_W-1:0] EVT_SEND    = 3'd1;
  localparam logic [EVT_W-1:0] EVT_DELIVER = 3'd2;
  localparam logic [EVT_W-1:0] EVT_STATUS  = 3'd3;
  localparam logic [EVT_W-1:0] EVT_DROP    = 3'd4;
  localparam logic [EVT_W-1:0] EVT_FULL    = 3'd5;

  // Classified operations handed from the front end to the back end.
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_NONE    = 3'd0;
  localparam logic [OP_W-1:0] OP_TICK    = 3'd1;
  localparam logic [OP_W-1:0] OP_ENQ     = 3'd2;
  localparam logic [OP_W-1:0] OP_REPLY   = 3'd3;
  localparam logic [OP_W-1:0] OP_STATUS  = 3'd4;
  localparam logic [OP_W-1:0] OP_CONNECT = 3'd5;
  localparam logic [OP_W-1:0] OP_DROP    = 3'd6;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [TAG_W-1:0]    req_tag;
    logic                rx_is_reply;
    logic [SEQ_W-1:0]    rx_seq;
    logic [ACTION_W-1:0] rx_action;
  } item_t;

  typedef struct packed {
    logic [EVT_W-1:0] event_res;
    logic [TAG_W-1:0] tag;
    logic [SEQ_W-1:0] send_seq;
    logic             send_close;
    logic             link_up;
  } result_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [TAG_W-1:0] tag;
    logic [SEQ_W-1:0] seq;
  } work_t;

endpackage

`default_nettype wire

FILE: rtl/swrq_fifo.sv
// ----------------------------------------------------------------------------
// swrq_fifo
// Two-entry queue that decouples a producer from a consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module swrq_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [WIDTH-1:0] din,
  output logic                  empty,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout
);

  logic [WIDTH-1:0] data [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  // Status and head entry.
  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign dout    = data[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      data[wr_ptr] <= din;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/swrq_front.sv
// ----------------------------------------------------------------------------
// swrq_front
// Accepts input transactions, classifies them and queues the work.
// ----------------------------------------------------------------------------
`default_nettype none

module swrq_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  output logic                 full,
  input  wire swrq_pkg::item_t item,
  output swrq_pkg::work_t      work,
  output logic                 work_empty,
  input  wire logic            work_pop
);

  swrq_pkg::work_t classified;

  // Turn the command and the received header into one operation.
  always_comb begin
    classified.tag = item.req_tag;
    classified.seq = item.rx_seq;
    case (item.cmd)
      swrq_pkg::CMD_TICK:    classified.op = swrq_pkg::OP_TICK;
      swrq_pkg::CMD_ENQ:     classified.op = swrq_pkg::OP_ENQ;
      swrq_pkg::CMD_RX: begin
        if (item.rx_action == swrq_pkg::ACTION_RESET) begin
          classified.op = swrq_pkg::OP_DROP;
        end else if (item.rx_is_reply) begin
          classified.op = swrq_pkg::OP_REPLY;
        end else begin
          classified.op = swrq_pkg::OP_STATUS;
        end
      end
      swrq_pkg::CMD_CONNECT: classified.op = swrq_pkg::OP_CONNECT;
      swrq_pkg::CMD_DISC:    classified.op = swrq_pkg::OP_DROP;
      default:               classified.op = swrq_pkg::OP_NONE;
    endcase
  end

  // Work queue toward the back end.
  swrq_fifo #(
    .WIDTH ($bits(swrq_pkg::work_t))
  ) u_work_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .din   (classified),
    .empty (work_empty),
    .pop   (work_pop),
    .dout  (work)
  );

endmodule

`default_nettype wire

FILE: rtl/swrq_back.sv
// ----------------------------------------------------------------------------
// swrq_back
// Holds link and request state; does one operation per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module swrq_back #(
  parameter int QUEUE_DEPTH = swrq_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = swrq_pkg::TAG_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [swrq_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [swrq_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire swrq_pkg::work_t                     work,
  input  wire logic                                work_empty,
  output logic                                     work_pop,
  output swrq_pkg::result_t                        result,
  output logic                                     empty,
  input  wire logic                                pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  // Configuration registers.
  logic [swrq_pkg::AGE_W-1:0]   timeout_ticks;
  logic [swrq_pkg::RETRY_W-1:0] max_retries;

  // Request queue and head state.
  logic [TAG_BITS-1:0]          pending_tags [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]          head_tag;
  logic [PTR_W-1:0]             rd_ptr, rd_ptr_next;
  logic [PTR_W-1:0]             wr_ptr, wr_ptr_next;
  logic [CNT_W-1:0]             fill_count, fill_count_next;
  logic [swrq_pkg::SEQ_W-1:0]   head_seq, head_seq_next;
  logic                         head_sent, head_sent_next;
  logic [swrq_pkg::AGE_W-1:0]   head_age, head_age_next;
  logic [swrq_pkg::RETRY_W-1:0] head_retries, head_retries_next;
  logic [swrq_pkg::SEQ_W-1:0]   next_seq, next_seq_next;
  logic                         connected, connected_next;

  // Operation control.
  logic                         res_full;
  logic                         fire;
  logic                         do_write;
  logic                         drop;
  logic                         fresh;
  logic                         due;
  logic [swrq_pkg::AGE_W-1:0]   age_inc;
  logic [TAG_BITS-1:0]          tag_in;
  swrq_pkg::result_t            res;

  assign fire     = !work_empty && !res_full;
  assign work_pop = fire;
  assign tag_in   = TAG_BITS'(work.tag);
  assign age_inc  = (head_age == swrq_pkg::AGE_MAX) ? head_age
                                                    : head_age + 1'b1;
  assign due      = head_sent ? (age_inc > timeout_ticks) : 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= swrq_pkg::TIMEOUT_RST;
      max_retries   <= swrq_pkg::RETRIES_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        swrq_pkg::REG_TIMEOUT: timeout_ticks <= cfg_data;
        swrq_pkg::REG_RETRIES: max_retries   <= cfg_data[swrq_pkg::RETRY_W-1:0];
        default: ;
      endcase
    end
  end

  // Execute one operation and build its result.
  always_comb begin
    rd_ptr_next       = rd_ptr;
    wr_ptr_next       = wr_ptr;
    fill_count_next   = fill_count;
    head_seq_next     = head_seq;
    head_sent_next    = head_sent;
    head_age_next     = head_age;
    head_retries_next = head_retries;
    next_seq_next     = next_seq;
    connected_next    = connected;
    do_write          = 1'b0;
    drop              = 1'b0;
    fresh             = 1'b0;
    res               = '0;

    if (fire) begin
      case (work.op)
        swrq_pkg::OP_TICK: begin
          if (fill_count != '0) begin
            if (head_sent) begin
              head_age_next = age_inc;
            end
            if (due) begin
              if (head_retries > max_retries) begin
                drop = 1'b1;
              end else begin
                head_seq_next  = next_seq;
                head_sent_next = 1'b1;
                head_age_next  = '0;
                if (head_retries != swrq_pkg::RETRY_MAX) begin
                  head_retries_next = head_retries + 1'b1;
                end
                res.event_res = swrq_pkg::EVT_SEND;
                res.tag       = swrq_pkg::TAG_W'(head_tag);
                res.send_seq  = next_seq;
              end
            end
          end
        end
        swrq_pkg::OP_ENQ: begin
          if (fill_count == CNT_FULL) begin
            res.event_res = swrq_pkg::EVT_FULL;
            res.tag       = work.tag;
          end else begin
            if (fill_count == '0) begin
              fresh = 1'b1;
            end
            do_write        = 1'b1;
            wr_ptr_next     = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
            fill_count_next = fill_count + 1'b1;
          end
        end
        swrq_pkg::OP_REPLY: begin
          if (fill_count != '0) begin
            if (head_seq == work.seq) begin
              res.event_res   = swrq_pkg::EVT_DELIVER;
              res.tag         = swrq_pkg::TAG_W'(head_tag);
              rd_ptr_next     = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
              fill_count_next = fill_count - 1'b1;
              next_seq_next   = next_seq + 1'b1;
              fresh           = 1'b1;
            end else begin
              drop = 1'b1;
            end
          end
        end
        swrq_pkg::OP_STATUS:  res.event_res  = swrq_pkg::EVT_STATUS;
        swrq_pkg::OP_CONNECT: connected_next = 1'b1;
        swrq_pkg::OP_DROP:    drop           = 1'b1;
        default: ;
      endcase

      // Link drop empties the queue and restarts the sequence.
      if (drop) begin
        res.event_res   = swrq_pkg::EVT_DROP;
        res.send_close  = connected;
        connected_next  = 1'b0;
        next_seq_next   = '0;
        rd_ptr_next     = '0;
        wr_ptr_next     = '0;
        fill_count_next = '0;
        fresh           = 1'b1;
      end

      // A new head starts unsent with cleared counters.
      if (fresh) begin
        head_seq_next     = '0;
        head_sent_next    = 1'b0;
        head_age_next     = '0;
        head_retries_next = '0;
      end

      res.link_up = connected_next;
    end
  end

  // Tag store with a registered head read; a write to the new head bypasses.
  always_ff @(posedge clk) begin
    if (do_write) begin
      pending_tags[wr_ptr] <= tag_in;
    end
    if (do_write && (wr_ptr == rd_ptr_next)) begin
      head_tag <= tag_in;
    end else begin
      head_tag <= pending_tags[rd_ptr_next];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr       <= '0;
      wr_ptr       <= '0;
      fill_count   <= '0;
      head_seq     <= '0;
      head_sent    <= 1'b0;
      head_age     <= '0;
      head_retries <= '0;
      next_seq     <= '0;
      connected    <= 1'b0;
    end else begin
      rd_ptr       <= rd_ptr_next;
      wr_ptr       <= wr_ptr_next;
      fill_count   <= fill_count_next;
      head_seq     <= head_seq_next;
      head_sent    <= head_sent_next;
      head_age     <= head_age_next;
      head_retries <= head_retries_next;
      next_seq     <= next_seq_next;
      connected    <= connected_next;
    end
  end

  // Result queue toward the consumer.
  swrq_fifo #(
    .WIDTH ($bits(swrq_pkg::result_t))
  ) u_result_q (
    .clk   (clk),
    .rst   (rst),
    .push  (fire),
    .full  (res_full),
    .din   (res),
    .empty (empty),
    .pop   (pop),
    .dout  (result)
  );

endmodule

`default_nettype wire

FILE: rtl/stop_and_wait_request_queue.sv
// ----------------------------------------------------------------------------
// stop_and_wait_request_queue
// An accepted transaction passes the work queue, then the result queue, to the head.
// Throughput is one transaction per cycle while the result queue has room.
// Synchronous reset empties both queues, clears link state, loads 1000 and 3.
// ----------------------------------------------------------------------------
`default_nettype none

module stop_and_wait_request_queue #(
  parameter int QUEUE_DEPTH = swrq_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = swrq_pkg::TAG_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  output logic                                 full,
  input  wire swrq_pkg::item_t                 item,
  output logic                                 empty,
  input  wire logic                            pop,
  output swrq_pkg::result_t                    result,
  input  wire logic                            cfg_we,
  input  wire logic [swrq_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [swrq_pkg::CFG_DATA_W-1:0] cfg_data
);

  swrq_pkg::work_t work;
  logic            work_empty;
  logic            work_pop;

  // Front end: accept and classify.
  swrq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .item       (item),
    .work       (work),
    .work_empty (work_empty),
    .work_pop   (work_pop)
  );

  // Back end: request queue, retry timer and link state.
  swrq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .work       (work),
    .work_empty (work_empty),
    .work_pop   (work_pop),
    .result     (result),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

`default_nettype wire

FILE: rtl/swrq_checker.sv
// ----------------------------------------------------------------------------
// swrq_checker
// Port-level checks of the request queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module swrq_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              full,
  input wire logic              empty,
  input wire logic              pop,
  input wire swrq_pkg::result_t result
);

  // After reset the result queue is empty and the work queue is not full.
  `SWRQ_ASSERT_ALWAYS(a_reset_empty, clk, (!rst && $past(rst)) |-> (empty && !full), "queues not empty after reset")

  // A waiting result holds until it is taken.
  `SWRQ_ASSERT(a_result_hold, clk, rst, (!empty && !pop) |=> (!empty && $stable(result)), "waiting result changed")

  // A close request only comes with a link drop.
  `SWRQ_ASSERT(a_close_on_drop, clk, rst, (!empty && result.send_close) |-> (result.event_res == swrq_pkg::EVT_DROP), "close without drop")

  // After a drop the link reads as down.
  `SWRQ_ASSERT(a_drop_link_down, clk, rst, (!empty && (result.event_res == swrq_pkg::EVT_DROP)) |-> !result.link_up, "link up after drop")

endmodule

bind stop_and_wait_request_queue swrq_checker u_swrq_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

`default_nettype wire
